### src/earc_pkg.sv
// Shared constants, types and codes of the EEPROM array read cache.
package earc_pkg;

    localparam int LINES_DEF      = 4;
    localparam int LINE_BYTES_DEF = 16;
    localparam int CHIPS_DEF      = 4;

    localparam int ADDR_W    = 18;
    localparam int DATA_W    = 8;
    localparam int CSIZE_W   = 16;
    localparam int CCOUNT_W  = 3;
    localparam int BLEN_W    = 5;
    localparam int CFG_IDX_W = 2;
    // Total memory size: chip size times a chip count of at most seven.
    localparam int TOTAL_W   = CSIZE_W + 4;

    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CSIZE_W-1:0]  CHIP_SIZE_RST  = 16'd8192;
    localparam logic [CCOUNT_W-1:0] CHIP_COUNT_RST = 3'd1;
    localparam logic [7:0]          BUS_BASE       = 8'hA0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHIP_SIZE  = 2'd0,
        REG_CHIP_COUNT = 2'd1
    } cfg_reg_t;

    typedef enum logic {
        ITEM_READ = 1'b0,
        ITEM_FILL = 1'b1
    } item_kind_t;

    typedef enum logic {
        RES_ANSWER = 1'b0,
        RES_BURST  = 1'b1
    } res_kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BUSY  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        item_kind_t          kind;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   fill_data;
    } item_t;

    typedef struct packed {
        res_kind_t           kind;
        status_t             status;
        logic [DATA_W-1:0]   read_data;
        logic [7:0]          bus_device;
        logic [CSIZE_W-1:0]  chip_address;
        logic [BLEN_W-1:0]   burst_length;
        logic                last;
    } res_t;

    // Effective chip size and total memory size, derived from the registers.
    typedef struct packed {
        logic [CSIZE_W-1:0]  chip_size;
        logic [TOTAL_W-1:0]  total;
    } cfg_t;

endpackage

### src/earc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module earc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/earc_front.sv
// Input side: accepts stream transfers, classifies them and queues them for the engine.
module earc_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [earc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    output logic                           q_valid,
    output earc_pkg::item_t                q_item,
    input  logic                           q_pop
);
    import earc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    item_t            in_item;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_item.kind      = s_tuser ? ITEM_FILL : ITEM_READ;
    assign in_item.addr      = s_tdata[ADDR_W-1:0];
    assign in_item.fill_data = s_tdata[ADDR_W +: DATA_W];

    assign s_tready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];

    assign push = s_tvalid && s_tready;
    assign pop  = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### src/earc_back.sv
// Cache engine: tag compare, line fill bookkeeping, chip mapping and result generation.
module earc_back #(
    parameter int LINES      = earc_pkg::LINES_DEF,
    parameter int LINE_BYTES = earc_pkg::LINE_BYTES_DEF,
    parameter int CHIPS      = earc_pkg::CHIPS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  earc_pkg::item_t   q_item,
    output logic              q_pop,
    input  earc_pkg::cfg_t    cfg,
    input  logic              out_free,
    output logic              res_load,
    output earc_pkg::res_t    res
);
    import earc_pkg::*;

    localparam int LI_W      = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int OFF_W     = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int LEN_W     = $clog2(LINE_BYTES + 1);
    localparam int RAM_DEPTH = LINES * LINE_BYTES;
    localparam int RA_W      = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int CH_W      = (CHIPS > 1) ? $clog2(CHIPS) : 1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_HITRD  = 6'b000100,
        S_MAP    = 6'b001000,
        S_BURST1 = 6'b010000,
        S_BURST2 = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    item_t              cur_reg, cur_next;
    logic               line_valid_reg [LINES];
    logic               line_valid_next [LINES];
    logic [ADDR_W-1:0]  line_start_reg [LINES];
    logic [ADDR_W-1:0]  line_start_next [LINES];
    logic [LEN_W-1:0]   line_len_reg [LINES];
    logic [LEN_W-1:0]   line_len_next [LINES];
    logic [LI_W-1:0]    vp_reg, vp_next;
    logic               fill_active_reg, fill_active_next;
    logic [LI_W-1:0]    fill_line_reg, fill_line_next;
    logic [LEN_W-1:0]   fill_count_reg, fill_count_next;
    logic [LEN_W-1:0]   fill_len_reg, fill_len_next;
    logic [DATA_W-1:0]  first_byte_reg, first_byte_next;
    logic [CH_W-1:0]    chip_reg, chip_next;
    logic [CSIZE_W-1:0] local_reg, local_next;

    // Lookup and mapping terms.
    logic [TOTAL_W-1:0] addr_w;
    logic               in_range;
    logic [ADDR_W-1:0]  diff [LINES];
    logic               hit_any;
    logic [LI_W-1:0]    hit_line;
    logic [OFF_W-1:0]   hit_off;
    logic [TOTAL_W-1:0] room;
    logic [LEN_W-1:0]   miss_len;
    logic [LI_W-1:0]    vp_inc;
    logic [LEN_W-1:0]   fill_cnt_inc;
    logic               fill_done;
    logic [DATA_W-1:0]  answer_byte;
    logic               is_fill;
    logic               emit_check;
    logic               proceed;
    logic [TOTAL_W-1:0] bnd;
    logic [CH_W-1:0]    map_chip;
    logic [TOTAL_W-1:0] map_base;
    logic [CSIZE_W-1:0] first_len;
    logic               single;

    logic               ram_wr_en, ram_rd_en;
    logic [RA_W-1:0]    ram_wr_addr, ram_rd_addr;
    logic [DATA_W-1:0]  ram_rd_data;

    assign addr_w   = TOTAL_W'(cur_reg.addr);
    assign in_range = (addr_w < cfg.total);
    assign is_fill  = (cur_reg.kind == ITEM_FILL);

    // Every line compares in parallel; the lowest matching line wins.
    always_comb begin
        hit_any  = 1'b0;
        hit_line = '0;
        hit_off  = '0;
        for (int i = 0; i < LINES; i++) begin
            diff[i] = cur_reg.addr - line_start_reg[i];
            if (!hit_any && line_valid_reg[i] && (cur_reg.addr >= line_start_reg[i]) &&
                (diff[i] < ADDR_W'(line_len_reg[i]))) begin
                hit_any  = 1'b1;
                hit_line = LI_W'(i);
                hit_off  = OFF_W'(diff[i]);
            end
        end
    end

    assign room     = cfg.total - addr_w;
    assign miss_len = (room > TOTAL_W'(LINE_BYTES)) ? LEN_W'(LINE_BYTES) : LEN_W'(room);
    assign vp_inc   = (vp_reg == LI_W'(LINES - 1)) ? '0 : vp_reg + 1'b1;

    assign fill_cnt_inc = fill_count_reg + 1'b1;
    assign fill_done    = (fill_cnt_inc == fill_len_reg);
    // The answer to a fill is the first byte of the new line.
    assign answer_byte  = (fill_count_reg == '0) ? cur_reg.fill_data : first_byte_reg;

    assign emit_check = is_fill ? (fill_active_reg && fill_done)
                                : (fill_active_reg || !in_range);
    assign proceed    = !emit_check || out_free;

    // Chip index is the count of chip boundaries at or below the address.
    always_comb begin
        map_chip = '0;
        map_base = '0;
        bnd      = '0;
        for (int k = 1; k < CHIPS; k++) begin
            bnd = TOTAL_W'(cfg.chip_size * k);
            if (addr_w >= bnd) begin
                map_chip = CH_W'(k);
                map_base = bnd;
            end
        end
    end

    assign first_len = cfg.chip_size - local_reg;
    assign single    = (first_len >= CSIZE_W'(fill_len_reg));

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    assign ram_wr_en   = (state_reg == S_CHECK) && is_fill && fill_active_reg;
    assign ram_wr_addr = RA_W'(fill_line_reg * LINE_BYTES + fill_count_reg);
    assign ram_rd_en   = (state_reg == S_CHECK) && !is_fill && !fill_active_reg &&
                         in_range && hit_any;
    assign ram_rd_addr = RA_W'(hit_line * LINE_BYTES + hit_off);

    always_comb begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        line_valid_next  = line_valid_reg;
        line_start_next  = line_start_reg;
        line_len_next    = line_len_reg;
        vp_next          = vp_reg;
        fill_active_next = fill_active_reg;
        fill_line_next   = fill_line_reg;
        fill_count_next  = fill_count_reg;
        fill_len_next    = fill_len_reg;
        first_byte_next  = first_byte_reg;
        chip_next        = chip_reg;
        local_next       = local_reg;
        res_load         = 1'b0;
        res              = '0;
        res.kind         = RES_ANSWER;
        res.status       = ST_OK;
        res.last         = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    cur_next   = q_item;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (proceed) begin
                    state_next = S_IDLE;
                    if (is_fill) begin
                        if (fill_active_reg) begin
                            if (fill_count_reg == '0) begin
                                first_byte_next = cur_reg.fill_data;
                            end
                            fill_count_next = fill_cnt_inc;
                            if (fill_done) begin
                                fill_active_next                = 1'b0;
                                line_valid_next[fill_line_reg] = 1'b1;
                                res.read_data                   = answer_byte;
                                res_load                        = 1'b1;
                            end
                        end
                    end else if (fill_active_reg) begin
                        res.status = ST_BUSY;
                        res_load   = 1'b1;
                    end else if (!in_range) begin
                        res.status = ST_RANGE;
                        res_load   = 1'b1;
                    end else if (hit_any) begin
                        state_next = S_HITRD;
                    end else begin
                        vp_next                 = vp_inc;
                        line_valid_next[vp_inc] = 1'b0;
                        line_start_next[vp_inc] = cur_reg.addr;
                        line_len_next[vp_inc]   = miss_len;
                        fill_active_next        = 1'b1;
                        fill_line_next          = vp_inc;
                        fill_count_next         = '0;
                        fill_len_next           = miss_len;
                        state_next              = S_MAP;
                    end
                end
            end
            S_HITRD: begin
                res.read_data = ram_rd_data;
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MAP: begin
                chip_next  = map_chip;
                local_next = CSIZE_W'(addr_w - map_base);
                state_next = S_BURST1;
            end
            S_BURST1: begin
                res.kind         = RES_BURST;
                res.bus_device   = BUS_BASE + 8'({chip_reg, 1'b0});
                res.chip_address = local_reg;
                res.burst_length = single ? BLEN_W'(fill_len_reg) : BLEN_W'(first_len);
                res.last         = single;
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = single ? S_IDLE : S_BURST2;
                end
            end
            S_BURST2: begin
                // The line runs on into the next chip from its address zero.
                res.kind         = RES_BURST;
                res.bus_device   = BUS_BASE + 8'({chip_reg, 1'b0}) + 8'd2;
                res.chip_address = '0;
                res.burst_length = BLEN_W'(fill_len_reg - LEN_W'(first_len));
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            vp_reg          <= '0;
            fill_active_reg <= 1'b0;
            fill_line_reg   <= '0;
            fill_count_reg  <= '0;
            fill_len_reg    <= '0;
            for (int i = 0; i < LINES; i++) begin
                line_valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg       <= state_next;
            vp_reg          <= vp_next;
            fill_active_reg <= fill_active_next;
            fill_line_reg   <= fill_line_next;
            fill_count_reg  <= fill_count_next;
            fill_len_reg    <= fill_len_next;
            line_valid_reg  <= line_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        line_start_reg <= line_start_next;
        line_len_reg   <= line_len_next;
        first_byte_reg <= first_byte_next;
        chip_reg       <= chip_next;
        local_reg      <= local_next;
    end

    earc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (cur_reg.fill_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

`ifndef SYNTHESIS
    // A line being filled must not answer hits.
    a_fill_line_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_active_reg |-> !line_valid_reg[fill_line_reg])
        else $error("line under fill is marked valid");

    a_fill_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_active_reg |-> (fill_count_reg < fill_len_reg))
        else $error("fill count reached fill length while fill active");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> out_free)
        else $error("result loaded while output register occupied");

    a_burst2_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BURST2) |->
            ($past(state_reg) == S_BURST1) || ($past(state_reg) == S_BURST2))
        else $error("second burst not preceded by first burst");
`endif

endmodule

### src/eeprom_array_read_cache.sv
// Top level of the EEPROM array read cache: configuration, queue, engine and output register.
// Busy, range and last-fill-byte answers come straight from the engine; a hit answer needs a
// line RAM read, and a miss yields one or two burst requests.
// The engine takes one queued item at a time and finishes it before it takes the next.
// Reset (aresetn low, synchronous) empties the queue, invalidates all lines and restores
// chip_size 8192 and chip_count 1.
module eeprom_array_read_cache #(
    parameter int LINES      = earc_pkg::LINES_DEF,
    parameter int LINE_BYTES = earc_pkg::LINE_BYTES_DEF,
    parameter int CHIPS      = earc_pkg::CHIPS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: addr[17:0], fill_data[25:18], zero pad[31:26]
    input  logic [earc_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: func (0 host read, 1 fill byte)
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: status[1:0], read_data[9:2], bus_device[17:10], chip_address[33:18],
    //          burst_length[38:34], zero pad[39]
    output logic [earc_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: kind (0 read answer, 1 burst request)
    output logic                           m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [earc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [earc_pkg::CSIZE_W-1:0]   cfg_data
);
    import earc_pkg::*;

    logic [CSIZE_W-1:0]  chip_size_reg, chip_size_next;
    logic [CCOUNT_W-1:0] chip_count_reg, chip_count_next;
    cfg_t                cfg_reg, cfg_next;
    logic [CSIZE_W-1:0]  size_eff;
    logic [3:0]          count_eff;

    logic                m_valid_reg, m_valid_next;
    res_t                m_res_reg, m_res_next;
    logic                out_free;
    logic                res_load;
    res_t                res;

    logic                q_valid;
    item_t               q_item;
    logic                q_pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        chip_size_next  = chip_size_reg;
        chip_count_next = chip_count_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_CHIP_SIZE) begin
                chip_size_next = cfg_data;
            end else if (cfg_index == REG_CHIP_COUNT) begin
                chip_count_next = cfg_data[CCOUNT_W-1:0];
            end
        end
    end

    // Chips smaller than a line act as one line; extra chips beyond CHIPS are ignored.
    assign size_eff  = (chip_size_reg < CSIZE_W'(LINE_BYTES)) ? CSIZE_W'(LINE_BYTES)
                                                              : chip_size_reg;
    assign count_eff = ({1'b0, chip_count_reg} > 4'(CHIPS)) ? 4'(CHIPS)
                                                            : {1'b0, chip_count_reg};

    assign cfg_next.chip_size = size_eff;
    assign cfg_next.total     = TOTAL_W'({4'b0, size_eff} * {16'b0, count_eff});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chip_size_reg  <= CHIP_SIZE_RST;
            chip_count_reg <= CHIP_COUNT_RST;
            cfg_reg        <= '0;
        end else begin
            chip_size_reg  <= chip_size_next;
            chip_count_reg <= chip_count_next;
            cfg_reg        <= cfg_next;
        end
    end

    earc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    earc_back #(
        .LINES      (LINES),
        .LINE_BYTES (LINE_BYTES),
        .CHIPS      (CHIPS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .cfg      (cfg_reg),
        .out_free (out_free),
        .res_load (res_load),
        .res      (res)
    );

    // The output register frees itself in the same cycle its transfer completes.
    assign out_free     = !m_valid_reg || m_tready;
    assign m_valid_next = res_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    assign m_res_next   = res_load ? res : m_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {1'b0, m_res_reg.burst_length, m_res_reg.chip_address,
                       m_res_reg.bus_device, m_res_reg.read_data, m_res_reg.status};

endmodule
